/* rtl/core/jdg_pkg.sv */
package jdg_pkg;

   localparam int JDN_W      = 24;
   localparam int MS_W       = 27;
   localparam int DATE_STAGES = 10;
   localparam int TIME_STAGES = 6;

   localparam logic [JDN_W-1:0] MJD_OFFSET      = 24'd2400001;
   localparam logic [JDN_W-1:0] GREGORIAN_START = 24'd2299161;
   localparam logic [MS_W-1:0]  MS_DAY_MAX      = 27'd86399999;

   // floor(ke * 30.6001) for ke = 0..15
   localparam logic [8:0] KE_DAYS [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
   };

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day_of_month;
   } date_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] second_ms;
   } tod_type;

endpackage

/* rtl/core/jdg_date_pipe.sv */
module jdg_date_pipe (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [jdg_pkg::JDN_W-1:0] jdn,
   output jdg_pkg::date_type         date
);
   import jdg_pkg::*;

   // s1: alpha numerator and reciprocal product
   logic             greg_in;
   logic [25:0]      na_in;
   logic [JDN_W-1:0] jdn1_ff;
   logic             greg1_ff;
   logic [25:0]      na1_ff;
   logic [34:0]      pa1_ff;

   assign greg_in = (jdn >= GREGORIAN_START);
   assign na_in   = greg_in ? 26'({jdn, 2'b00} - 26'd7468865) : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         jdn1_ff  <= jdn;
         greg1_ff <= greg_in;
         na1_ff   <= na_in;
         pa1_ff   <= 35'(na_in) * 35'd459;
      end
   end

   // s2: alpha estimate and remainder
   logic [8:0]       est2_in;
   logic [26:0]      rem2_wide;
   logic [JDN_W-1:0] jdn2_ff;
   logic             greg2_ff;
   logic [8:0]       est2_ff;
   logic [18:0]      rem2_ff;

   assign est2_in   = pa1_ff[34:26];
   assign rem2_wide = 27'(na1_ff) - 27'(est2_in) * 27'd146097;

   always_ff @(posedge clock) begin
      if (adv) begin
         jdn2_ff  <= jdn1_ff;
         greg2_ff <= greg1_ff;
         est2_ff  <= est2_in;
         rem2_ff  <= rem2_wide[18:0];
      end
   end

   // s3: Gregorian correction, kb and kc numerator
   logic [8:0]       alpha3;
   logic [24:0]      ka3;
   logic [JDN_W-1:0] kb3_in;
   logic [JDN_W-1:0] kb3_ff;
   logic [27:0]      nc3_ff;

   always_comb begin
      alpha3 = est2_ff + 9'(rem2_ff >= 19'd146097);
      ka3    = greg2_ff ? 25'(jdn2_ff) + 25'd1 + 25'(alpha3) - 25'(alpha3 >> 2)
                        : 25'(jdn2_ff);
      kb3_in = JDN_W'(ka3 + 25'd1524);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kb3_ff <= kb3_in;
         nc3_ff <= 28'(kb3_in) * 28'd20 - 28'd2442;
      end
   end

   // s4: kc reciprocal product
   logic [JDN_W-1:0] kb4_ff;
   logic [27:0]      nc4_ff;
   logic [43:0]      pc4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kb4_ff <= kb3_ff;
         nc4_ff <= nc3_ff;
         pc4_ff <= 44'(nc3_ff) * 44'd36746;
      end
   end

   // s5: kc estimate and remainder
   logic [14:0]      kc5_in;
   logic [27:0]      rem5_wide;
   logic [JDN_W-1:0] kb5_ff;
   logic [14:0]      kc5_ff;
   logic [13:0]      rem5_ff;

   assign kc5_in    = pc4_ff[42:28];
   assign rem5_wide = nc4_ff - 28'(kc5_in) * 28'd7305;

   always_ff @(posedge clock) begin
      if (adv) begin
         kb5_ff  <= kb4_ff;
         kc5_ff  <= kc5_in;
         rem5_ff <= rem5_wide[13:0];
      end
   end

   // s6: kc fix, kd and day offset within the March-based year
   logic [14:0] kc6_in;
   logic [25:0] kd6_wide;
   logic [JDN_W-1:0] kd6;
   logic [JDN_W-1:0] diff6_wide;
   logic [14:0] kc6_ff;
   logic [8:0]  diff6_ff;

   always_comb begin
      kc6_in     = kc5_ff + 15'(rem5_ff >= 14'd7305);
      kd6_wide   = 26'(kc6_in) * 26'd1461;
      kd6        = JDN_W'(kd6_wide >> 2);
      diff6_wide = kb5_ff - kd6;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kc6_ff   <= kc6_in;
         diff6_ff <= diff6_wide[8:0];
      end
   end

   // s7: ke numerator
   logic [14:0] kc7_ff;
   logic [8:0]  diff7_ff;
   logic [22:0] ne7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kc7_ff   <= kc6_ff;
         diff7_ff <= diff6_ff;
         ne7_ff   <= 23'(diff6_ff) * 23'd10000;
      end
   end

   // s8: ke reciprocal product
   logic [14:0] kc8_ff;
   logic [8:0]  diff8_ff;
   logic [22:0] ne8_ff;
   logic [27:0] pe8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kc8_ff   <= kc7_ff;
         diff8_ff <= diff7_ff;
         ne8_ff   <= ne7_ff;
         pe8_ff   <= 28'(ne7_ff) * 28'd27;
      end
   end

   // s9: ke estimate and remainder
   logic [3:0]  ke9_in;
   logic [22:0] rem9_wide;
   logic [14:0] kc9_ff;
   logic [8:0]  diff9_ff;
   logic [3:0]  ke9_ff;
   logic [19:0] rem9_ff;

   assign ke9_in    = pe8_ff[26:23];
   assign rem9_wide = ne8_ff - 23'(ke9_in) * 23'd306001;

   always_ff @(posedge clock) begin
      if (adv) begin
         kc9_ff   <= kc8_ff;
         diff9_ff <= diff8_ff;
         ke9_ff   <= ke9_in;
         rem9_ff  <= rem9_wide[19:0];
      end
   end

   // s10: ke fix, day, month, year with the February fix-ups
   logic [3:0]  ke10;
   logic [8:0]  day10;
   logic [3:0]  month10;
   date_type    date_in;
   date_type    date_ff;

   always_comb begin
      ke10    = ke9_ff + 4'(rem9_ff >= 20'd306001);
      day10   = diff9_ff - KE_DAYS[ke10];
      month10 = (ke10 > 4'd13) ? ke10 - 4'd13 : ke10 - 4'd1;
      if (month10 == 4'd2 && day10 > 9'd28) begin
         day10 = 9'd29;
      end
      date_in.month        = month10;
      date_in.day_of_month = day10[4:0];
      if (month10 == 4'd2 && day10 == 9'd29 && ke10 == 4'd3) begin
         date_in.year = 16'(kc9_ff) - 16'sd4716;
      end else if (month10 > 4'd2) begin
         date_in.year = 16'(kc9_ff) - 16'sd4716;
      end else begin
         date_in.year = 16'(kc9_ff) - 16'sd4715;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

/* rtl/core/jdg_time_pipe.sv */
module jdg_time_pipe (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [jdg_pkg::MS_W-1:0] ms,
   output jdg_pkg::tod_type         tod
);
   import jdg_pkg::*;

   localparam int TIME_PAD = DATE_STAGES - TIME_STAGES;

   // t1: hour reciprocal product
   logic [MS_W-1:0] ms1_ff;
   logic [32:0]     ph1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ms1_ff <= ms;
         ph1_ff <= 33'(ms) * 33'd37;
      end
   end

   // t2: hour estimate and remainder
   logic [4:0]      hr2_in;
   logic [MS_W-1:0] rem2_wide;
   logic [4:0]      hr2_ff;
   logic [22:0]     rem2_ff;

   assign hr2_in    = ph1_ff[31:27];
   assign rem2_wide = ms1_ff - 27'(hr2_in) * 27'd3600000;

   always_ff @(posedge clock) begin
      if (adv) begin
         hr2_ff  <= hr2_in;
         rem2_ff <= rem2_wide[22:0];
      end
   end

   // t3: hour fix
   logic        hfix3;
   logic [22:0] rem3_wide;
   logic [4:0]  hr3_ff;
   logic [21:0] rem3_ff;

   assign hfix3     = (rem2_ff >= 23'd3600000);
   assign rem3_wide = hfix3 ? rem2_ff - 23'd3600000 : rem2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hr3_ff  <= hr2_ff + 5'(hfix3);
         rem3_ff <= rem3_wide[21:0];
      end
   end

   // t4: minute reciprocal product
   logic [4:0]  hr4_ff;
   logic [21:0] rem4_ff;
   logic [28:0] pm4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hr4_ff  <= hr3_ff;
         rem4_ff <= rem3_ff;
         pm4_ff  <= 29'(rem3_ff) * 29'd69;
      end
   end

   // t5: minute estimate and remainder
   logic [5:0]  mn5_in;
   logic [21:0] rem5_wide;
   logic [4:0]  hr5_ff;
   logic [5:0]  mn5_ff;
   logic [16:0] rem5_ff;

   assign mn5_in    = pm4_ff[27:22];
   assign rem5_wide = rem4_ff - 22'(mn5_in) * 22'd60000;

   always_ff @(posedge clock) begin
      if (adv) begin
         hr5_ff  <= hr4_ff;
         mn5_ff  <= mn5_in;
         rem5_ff <= rem5_wide[16:0];
      end
   end

   // t6: minute fix, then delay to line up with the date path
   logic        mfix6;
   logic [16:0] sec6_wide;
   tod_type     tod6_in;
   tod_type     pad_ff [TIME_PAD+1];

   always_comb begin
      mfix6             = (rem5_ff >= 17'd60000);
      sec6_wide         = mfix6 ? rem5_ff - 17'd60000 : rem5_ff;
      tod6_in.hour      = hr5_ff;
      tod6_in.minute    = mn5_ff + 6'(mfix6);
      tod6_in.second_ms = sec6_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pad_ff[0] <= tod6_in;
         for (int i = 1; i <= TIME_PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
   end

   assign tod = pad_ff[TIME_PAD];

endmodule

/* rtl/core/julian_day_to_gregorian_unit.sv */
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | req_tdata: day_number, day_ms
// rsp     | out | rsp_tvalid/tready    | rsp_tdata: year, month, day, hour, minute, second_ms
// csr     | in  | csr_wr_en            | csr_wr_data: modified_day_mode
//
// One item per cycle while the output is not stalled. The date path sets the depth:
// three reciprocal divides, each a product stage, an estimate stage and a fix stage.
// Synchronous reset clears the valid bits and the mode register.
// All stages advance together while the output is empty or being taken;
// a stall freezes the whole pipeline and req_tready drops.
module julian_day_to_gregorian_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // day_number[22:0], day_ms[49:23], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // year[15:0], month[19:16], day_of_month[24:20],
                                    // hour[29:25], minute[35:30], second_ms[51:36], zero pad
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // modified_day_mode
);
   import jdg_pkg::*;

   logic             adv;
   logic             mode_ff;
   logic [DATE_STAGES:0] vld_ff;
   logic [JDN_W-1:0] jdn_in;
   logic [MS_W-1:0]  ms_in;
   logic [JDN_W-1:0] jdn_ff;
   logic [MS_W-1:0]  ms_ff;
   date_type         date;
   tod_type          tod;

   assign adv        = !vld_ff[DATE_STAGES] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DATE_STAGES-1:0], req_tvalid};
      end
   end

   always_comb begin
      jdn_in = JDN_W'(req_tdata[22:0]) + (mode_ff ? MJD_OFFSET : '0);
      ms_in  = (req_tdata[49:23] > MS_DAY_MAX) ? MS_DAY_MAX : req_tdata[49:23];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         jdn_ff <= jdn_in;
         ms_ff  <= ms_in;
      end
   end

   jdg_date_pipe u_date (
      .clock (clock),
      .adv   (adv),
      .jdn   (jdn_ff),
      .date  (date)
   );

   jdg_time_pipe u_time (
      .clock (clock),
      .adv   (adv),
      .ms    (ms_ff),
      .tod   (tod)
   );

   assign rsp_tvalid = vld_ff[DATE_STAGES];
   assign rsp_tdata  = {4'd0, tod.second_ms, tod.minute, tod.hour,
                        date.day_of_month, date.month, date.year};

endmodule

/* rtl/core/jdg_checker.sv */
module jdg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [15:0] second_ms;

   assign month        = rsp_tdata[19:16];
   assign day_of_month = rsp_tdata[24:20];
   assign hour         = rsp_tdata[29:25];
   assign minute       = rsp_tdata[35:30];
   assign second_ms    = rsp_tdata[51:36];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled item changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> month >= 4'd1 && month <= 4'd12 &&
                     day_of_month >= 5'd1 && day_of_month <= 5'd31)
      else $error("date out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> hour <= 5'd23 && minute <= 6'd59 && second_ms <= 16'd59999)
      else $error("time of day out of range");

endmodule

bind julian_day_to_gregorian_unit jdg_checker u_jdg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
